// ===== rtl/set_assoc_lru_cache_sim_top_defines.svh =====
// Assertion macros for the cache simulator RTL.
`ifndef SET_ASSOC_LRU_CACHE_SIM_TOP_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_SIM_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SALRU_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SALRU_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/salru_pkg.sv =====
`timescale 1ns / 1ps

package salru_pkg;

   localparam int CNT_W        = 32;
   localparam int AGE_W        = CNT_W;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 6;
   localparam int SET_CFG_W    = 4;
   localparam int WAYS_CFG_W   = 4;
   localparam int OFFSET_CFG_W = 6;
   // Set bits plus offset bits, wide enough for the largest sum.
   localparam int SHIFT_W      = OFFSET_CFG_W + 1;

   typedef enum logic [1:0] {
      CMD_FETCH  = 2'd0,
      CMD_LOAD   = 2'd1,
      CMD_STORE  = 2'd2,
      CMD_MODIFY = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SET_BITS    = 2'd0,
      CSR_WAYS        = 2'd1,
      CSR_OFFSET_BITS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic hit;
      logic miss;
      logic evict;
   } lookup_flags_type;

   typedef struct packed {
      logic             was_hit;
      logic             was_miss;
      logic             was_eviction;
      logic [CNT_W-1:0] hit_total;
      logic [CNT_W-1:0] miss_total;
      logic [CNT_W-1:0] eviction_total;
   } rsp_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
   endfunction

endpackage

// ===== rtl/salru_lookup.sv =====
`timescale 1ns / 1ps

module salru_lookup #(
   parameter int MAX_WAYS  = 8,
   parameter int ADDR_BITS = 64
) (
   input  logic [MAX_WAYS-1:0]                          way_en,
   input  logic [MAX_WAYS-1:0]                          row_valid,
   input  logic [MAX_WAYS-1:0][salru_pkg::AGE_W-1:0]    row_age,
   input  logic [MAX_WAYS-1:0][ADDR_BITS-1:0]           row_tag,
   input  logic [ADDR_BITS-1:0]                         tag,
   output salru_pkg::lookup_flags_type                  flags,
   output logic [MAX_WAYS-1:0]                          new_valid,
   output logic [MAX_WAYS-1:0][salru_pkg::AGE_W-1:0]    new_age,
   output logic [MAX_WAYS-1:0][ADDR_BITS-1:0]           new_tag
);
   import salru_pkg::*;

   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int LVL    = $clog2(MAX_WAYS);
   localparam int TREE_N = 1 << LVL;

   logic             hit_any;
   logic [WAY_W-1:0] hit_way;
   logic             free_any;
   logic [WAY_W-1:0] free_way;
   logic [WAY_W-1:0] victim;
   logic [WAY_W-1:0] touched;

   logic             nd_present [0:LVL][0:TREE_N-1];
   logic [AGE_W-1:0] nd_age     [0:LVL][0:TREE_N-1];
   logic [WAY_W-1:0] nd_idx     [0:LVL][0:TREE_N-1];

   // Lowest matching way and lowest empty way; the loop runs downward so
   // that the lowest index is written last.
   always_comb begin
      hit_any  = 1'b0;
      hit_way  = '0;
      free_any = 1'b0;
      free_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (way_en[w] && row_valid[w] && (row_tag[w] == tag)) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (way_en[w] && !row_valid[w]) begin
            free_any = 1'b1;
            free_way = WAY_W'(w);
         end
      end
   end

   // Oldest way by a pairwise tree. The right node wins only when the left is
   // absent or the right is strictly older, which keeps the lowest index on a tie.
   always_comb begin
      for (int l = 0; l <= LVL; l++) begin
         for (int i = 0; i < TREE_N; i++) begin
            nd_present[l][i] = 1'b0;
            nd_age[l][i]     = '0;
            nd_idx[l][i]     = '0;
         end
      end
      for (int i = 0; i < TREE_N; i++) begin
         if (i < MAX_WAYS) begin
            nd_present[0][i] = way_en[i];
            nd_age[0][i]     = row_age[i];
            nd_idx[0][i]     = WAY_W'(i);
         end
      end
      for (int l = 0; l < LVL; l++) begin
         for (int i = 0; i < (TREE_N >> (l + 1)); i++) begin
            if (nd_present[l][2*i+1] &&
                (!nd_present[l][2*i] || (nd_age[l][2*i+1] > nd_age[l][2*i]))) begin
               nd_present[l+1][i] = 1'b1;
               nd_age[l+1][i]     = nd_age[l][2*i+1];
               nd_idx[l+1][i]     = nd_idx[l][2*i+1];
            end else begin
               nd_present[l+1][i] = nd_present[l][2*i];
               nd_age[l+1][i]     = nd_age[l][2*i];
               nd_idx[l+1][i]     = nd_idx[l][2*i];
            end
         end
      end
      victim = nd_idx[LVL][0];
   end

   always_comb begin
      if (hit_any) begin
         touched = hit_way;
      end else if (free_any) begin
         touched = free_way;
      end else begin
         touched = victim;
      end

      flags.hit   = hit_any;
      flags.miss  = !hit_any;
      flags.evict = !hit_any && !free_any;

      for (int w = 0; w < MAX_WAYS; w++) begin
         new_valid[w] = row_valid[w];
         new_tag[w]   = row_tag[w];
         new_age[w]   = row_age[w];
         if (WAY_W'(w) == touched) begin
            new_valid[w] = 1'b1;
            new_tag[w]   = tag;
            new_age[w]   = '0;
         end else if (way_en[w]) begin
            new_age[w]   = sat_inc(row_age[w]);
         end
      end
   end

endmodule

// ===== rtl/set_assoc_lru_cache_sim_top.sv =====
`timescale 1ns / 1ps
// Set-associative cache simulator with least-recently-used replacement.
// Request channel (req_): one memory access per word, a command and a byte
// address. Response channel (rsp_): one word per request with hit, miss and
// eviction flags and the three saturating running totals.
// Configuration (csr_): set bits, ways in use and block offset bits, written
// by index while no request is outstanding; csr_ready is always high.
// Each set is one row of a single-port-per-side memory holding valid bits,
// ages and tags for every way. An access reads its row into rd_row_ff at the
// accept edge; in ST_EVAL all ways are compared in parallel, the row is
// written back (not for a fetch) and the response register is loaded, or the
// hold register while a response still waits. No new request is taken until
// that read-modify-write of the row is done. After reset a clearing pass
// writes every row with req_ready low; configuration writes are taken.
// A response waiting on rsp_ready does not stop the next request: a second
// result register holds one more word, and only when both are full does
// req_ready drop for back-pressure.
`include "set_assoc_lru_cache_sim_top_defines.svh"

module set_assoc_lru_cache_sim_top #(
   parameter int MAX_SET_BITS = 8,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_BITS    = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  salru_pkg::cmd_type                   req_cmd,
   input  logic [ADDR_BITS-1:0]                 req_address,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_was_hit,
   output logic                                 rsp_was_miss,
   output logic                                 rsp_was_eviction,
   output logic [salru_pkg::CNT_W-1:0]          rsp_hit_total,
   output logic [salru_pkg::CNT_W-1:0]          rsp_miss_total,
   output logic [salru_pkg::CNT_W-1:0]          rsp_eviction_total,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [salru_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [salru_pkg::CSR_DATA_W-1:0]     csr_data
);
   import salru_pkg::*;

   localparam int NUM_SETS   = 1 << MAX_SET_BITS;
   localparam int IDX_W      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WCNT_W     = $clog2(MAX_WAYS + 1);
   localparam int WAYS_CMP_W = WAYS_CFG_W + 1;

   typedef struct packed {
      logic [MAX_WAYS-1:0]                valid;
      logic [MAX_WAYS-1:0][AGE_W-1:0]     age;
      logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
   } row_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL
   } state_type;

   row_type mem [NUM_SETS];
   row_type rd_row_ff;
   row_type mem_wdata;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;

   state_type state_ff, state_in;
   logic [IDX_W-1:0]        clr_idx_ff, clr_idx_in;
   logic [SET_CFG_W-1:0]    cfg_set_bits_ff, cfg_set_bits_in;
   logic [WAYS_CFG_W-1:0]   cfg_ways_ff, cfg_ways_in;
   logic [OFFSET_CFG_W-1:0] cfg_offset_ff, cfg_offset_in;
   logic [ADDR_BITS-1:0]    tag_ff, tag_in;
   logic [IDX_W-1:0]        set_ff, set_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [CNT_W-1:0]        hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]        miss_cnt_ff, miss_cnt_in;
   logic [CNT_W-1:0]        evict_cnt_ff, evict_cnt_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 hold_ff, hold_in;
   logic                    hold_valid_ff, hold_valid_in;

   logic [SET_CFG_W-1:0] s_eff;
   logic [SHIFT_W-1:0]   tag_shift;
   logic [ADDR_BITS-1:0] req_tag;
   logic [IDX_W-1:0]     req_set;
   logic [WCNT_W-1:0]    ways_eff;
   logic [MAX_WAYS-1:0]  way_en;
   logic                 req_fire;
   logic                 rsp_take;

   lookup_flags_type                   lk_flags;
   logic [MAX_WAYS-1:0]                lk_valid;
   logic [MAX_WAYS-1:0][AGE_W-1:0]     lk_age;
   logic [MAX_WAYS-1:0][ADDR_BITS-1:0] lk_tag;

   logic [CNT_W-1:0] hit_once;
   logic [CNT_W-1:0] hit_upd;
   logic [CNT_W-1:0] miss_upd;
   logic [CNT_W-1:0] evict_upd;
   rsp_type          new_res;

   assign req_ready = (state_ff == ST_IDLE) && !hold_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign csr_ready = 1'b1;

   // Address split, clamped configuration and the ways in use.
   always_comb begin
      if (cfg_set_bits_ff > SET_CFG_W'(MAX_SET_BITS)) begin
         s_eff = SET_CFG_W'(MAX_SET_BITS);
      end else begin
         s_eff = cfg_set_bits_ff;
      end
      tag_shift = SHIFT_W'(s_eff) + SHIFT_W'(cfg_offset_ff);
      // A shift by the full width or more leaves a zero tag.
      req_tag   = req_address >> tag_shift;
      req_set   = IDX_W'(req_address >> cfg_offset_ff) & ~({IDX_W{1'b1}} << s_eff)
                  & IDX_W'(NUM_SETS - 1);

      if (cfg_ways_ff == '0) begin
         ways_eff = WCNT_W'(1);
      end else if ({1'b0, cfg_ways_ff} > WAYS_CMP_W'(MAX_WAYS)) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(cfg_ways_ff);
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         way_en[w] = WCNT_W'(w) < ways_eff;
      end
   end

   salru_lookup #(
      .MAX_WAYS  (MAX_WAYS),
      .ADDR_BITS (ADDR_BITS)
   ) u_lookup (
      .way_en    (way_en),
      .row_valid (rd_row_ff.valid),
      .row_age   (rd_row_ff.age),
      .row_tag   (rd_row_ff.tag),
      .tag       (tag_ff),
      .flags     (lk_flags),
      .new_valid (lk_valid),
      .new_age   (lk_age),
      .new_tag   (lk_tag)
   );

   always_comb begin
      hit_once  = lk_flags.hit ? sat_inc(hit_cnt_ff) : hit_cnt_ff;
      hit_upd   = (cmd_ff == CMD_MODIFY) ? sat_inc(hit_once) : hit_once;
      miss_upd  = lk_flags.miss ? sat_inc(miss_cnt_ff) : miss_cnt_ff;
      evict_upd = lk_flags.evict ? sat_inc(evict_cnt_ff) : evict_cnt_ff;

      if (cmd_ff == CMD_FETCH) begin
         new_res.was_hit        = 1'b0;
         new_res.was_miss       = 1'b0;
         new_res.was_eviction   = 1'b0;
         new_res.hit_total      = hit_cnt_ff;
         new_res.miss_total     = miss_cnt_ff;
         new_res.eviction_total = evict_cnt_ff;
      end else begin
         new_res.was_hit        = lk_flags.hit;
         new_res.was_miss       = lk_flags.miss;
         new_res.was_eviction   = lk_flags.evict;
         new_res.hit_total      = hit_upd;
         new_res.miss_total     = miss_upd;
         new_res.eviction_total = evict_upd;
      end
   end

   always_comb begin
      state_in        = state_ff;
      clr_idx_in      = clr_idx_ff;
      cfg_set_bits_in = cfg_set_bits_ff;
      cfg_ways_in     = cfg_ways_ff;
      cfg_offset_in   = cfg_offset_ff;
      tag_in          = tag_ff;
      set_in          = set_ff;
      cmd_in          = cmd_ff;
      hit_cnt_in      = hit_cnt_ff;
      miss_cnt_in     = miss_cnt_ff;
      evict_cnt_in    = evict_cnt_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff;
      hold_in         = hold_ff;
      hold_valid_in   = hold_valid_ff;
      mem_we          = 1'b0;
      mem_waddr       = set_ff;
      mem_wdata.valid = lk_valid;
      mem_wdata.age   = lk_age;
      mem_wdata.tag   = lk_tag;

      if (rsp_take) begin
         if (hold_valid_ff) begin
            rsp_in        = hold_ff;
            hold_valid_in = 1'b0;
         end else begin
            rsp_valid_in  = 1'b0;
         end
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SET_BITS:    cfg_set_bits_in = csr_data[SET_CFG_W-1:0];
            CSR_WAYS:        cfg_ways_in     = csr_data[WAYS_CFG_W-1:0];
            CSR_OFFSET_BITS: cfg_offset_in   = csr_data[OFFSET_CFG_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = '0;
            clr_idx_in = clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == IDX_W'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               tag_in   = req_tag;
               set_in   = req_set;
               cmd_in   = req_cmd;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (cmd_ff != CMD_FETCH) begin
               mem_we       = 1'b1;
               hit_cnt_in   = hit_upd;
               miss_cnt_in  = miss_upd;
               evict_cnt_in = evict_upd;
            end
            // The hold register is empty here, since req_ready required it.
            if (!rsp_valid_ff || rsp_take) begin
               rsp_in        = new_res;
               rsp_valid_in  = 1'b1;
            end else begin
               hold_in       = new_res;
               hold_valid_in = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Row memory: one write and one registered read per cycle. The state
   // machine keeps a read from meeting a write-back of the same row.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_row_ff <= mem[req_set];
      end
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      set_ff  <= set_in;
      cmd_ff  <= cmd_in;
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_idx_ff      <= '0;
         cfg_set_bits_ff <= '0;
         cfg_ways_ff     <= WAYS_CFG_W'(1);
         cfg_offset_ff   <= '0;
         hit_cnt_ff      <= '0;
         miss_cnt_ff     <= '0;
         evict_cnt_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         hold_valid_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_idx_ff      <= clr_idx_in;
         cfg_set_bits_ff <= cfg_set_bits_in;
         cfg_ways_ff     <= cfg_ways_in;
         cfg_offset_ff   <= cfg_offset_in;
         hit_cnt_ff      <= hit_cnt_in;
         miss_cnt_ff     <= miss_cnt_in;
         evict_cnt_ff    <= evict_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
         hold_valid_ff   <= hold_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_was_hit        = rsp_ff.was_hit;
   assign rsp_was_miss       = rsp_ff.was_miss;
   assign rsp_was_eviction   = rsp_ff.was_eviction;
   assign rsp_hit_total      = rsp_ff.hit_total;
   assign rsp_miss_total     = rsp_ff.miss_total;
   assign rsp_eviction_total = rsp_ff.eviction_total;

   `SALRU_ASSERT_NOW(a_hold_behind_rsp, hold_valid_ff, rsp_valid_ff, "hold word without a response word")
   `SALRU_ASSERT_NEXT(a_accept_to_eval, req_fire, state_ff == ST_EVAL, "accepted word not evaluated next cycle")
   `SALRU_ASSERT_NOW(a_rsp_from_eval, $rose(rsp_valid_ff), $past(state_ff == ST_EVAL), "response appeared without a lookup")
   `SALRU_ASSERT_NOW(a_evict_le_miss, rsp_valid_ff, rsp_ff.miss_total >= rsp_ff.eviction_total, "eviction total exceeds miss total")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import salru_pkg::*;

   localparam int TB_SET_BITS = 8;
   localparam int TB_WAYS     = 8;
   localparam int TB_LINES    = (1 << TB_SET_BITS) * TB_WAYS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_PRINTED = 40;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      cmd_type     cmd;
      logic [63:0] addr;
   } access_word_type;

   typedef enum int {
      DRAIN_FREE,
      DRAIN_COIN,
      DRAIN_EVERY_FOURTH,
      DRAIN_TRICKLE
   } drain_mode_type;

   logic clock;
   logic reset = 1'b1;

   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   cmd_type                req_cmd     = CMD_FETCH;
   logic [63:0]            req_address = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   logic                   rsp_was_hit;
   logic                   rsp_was_miss;
   logic                   rsp_was_eviction;
   logic [CNT_W-1:0]       rsp_hit_total;
   logic [CNT_W-1:0]       rsp_miss_total;
   logic [CNT_W-1:0]       rsp_eviction_total;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   // Mirror of the cache contents and configuration.
   bit   [3:0]  cfg_set_bits    = 4'd0;
   bit   [3:0]  cfg_ways        = 4'd1;
   bit   [5:0]  cfg_offset_bits = 6'd0;
   bit          line_valid [TB_LINES];
   bit   [63:0] line_tag   [TB_LINES];
   bit   [31:0] line_age   [TB_LINES];
   bit   [31:0] hit_count;
   bit   [31:0] miss_count;
   bit   [31:0] eviction_count;

   access_word_type pending_access[$];
   rsp_type     predicted_lookups[$];
   logic [63:0] tag_pool[$];
   int          issued_count;
   int          accepted_count;
   int          error_count;
   int          cycle_count;
   int          burst_left;
   int          gap_left;
   int          drain_left;
   drain_mode_type drain_mode = DRAIN_FREE;

   set_assoc_lru_cache_sim_top #(
      .MAX_SET_BITS(TB_SET_BITS),
      .MAX_WAYS(TB_WAYS),
      .ADDR_BITS(64)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_address(req_address),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_was_hit(rsp_was_hit),
      .rsp_was_miss(rsp_was_miss),
      .rsp_was_eviction(rsp_was_eviction),
      .rsp_hit_total(rsp_hit_total),
      .rsp_miss_total(rsp_miss_total),
      .rsp_eviction_total(rsp_eviction_total),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   function automatic bit [31:0] count_up_sat(input bit [31:0] v);
      return (&v) ? v : v + 32'd1;
   endfunction

   function automatic int unsigned eff_set_bits();
      return (cfg_set_bits > TB_SET_BITS) ? TB_SET_BITS : cfg_set_bits;
   endfunction

   function automatic int unsigned eff_ways();
      if (cfg_ways == 0) return 1;
      return (cfg_ways > TB_WAYS) ? TB_WAYS : cfg_ways;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Looks up the set (not for a fetch), updates the mirrored lines and returns the word expected.
   function automatic rsp_type predict_lookup(input cmd_type cmd, input logic [63:0] addr);
      rsp_type     r;
      int unsigned sbits, ways, shift, base, victim, w;
      logic [63:0] tag;
      bit          found, have_free;
      bit   [31:0] oldest;
      r = '0;
      victim = 0;
      found = 0;
      have_free = 0;
      if (cmd != CMD_FETCH) begin
         sbits = eff_set_bits();
         ways  = eff_ways();
         shift = sbits + cfg_offset_bits;
         tag   = (shift >= 64) ? 64'd0 : addr >> shift;
         base  = TB_WAYS * 32'((addr >> cfg_offset_bits) & ((64'd1 << sbits) - 64'd1));
         for (w = 0; w < ways && !found; w++) begin
            if (!line_valid[base + w]) begin
               if (!have_free) begin
                  have_free = 1;
                  victim = w;
               end
            end else if (line_tag[base + w] == tag) begin
               found = 1;
               victim = w;
            end
         end
         if (found) begin
            r.was_hit = 1'b1;
            hit_count = count_up_sat(hit_count);
         end else begin
            r.was_miss = 1'b1;
            if (!have_free) begin
               // Oldest way goes; on equal ages the lowest way wins.
               oldest = line_age[base];
               victim = 0;
               for (w = 1; w < ways; w++) begin
                  if (line_age[base + w] > oldest) begin
                     oldest = line_age[base + w];
                     victim = w;
                  end
               end
               r.was_eviction = 1'b1;
               eviction_count = count_up_sat(eviction_count);
            end
            line_valid[base + victim] = 1;
            line_tag[base + victim] = tag;
            miss_count = count_up_sat(miss_count);
         end
         for (w = 0; w < ways; w++)
            line_age[base + w] = (w == victim) ? 32'd0 : count_up_sat(line_age[base + w]);
         if (cmd == CMD_MODIFY) hit_count = count_up_sat(hit_count);
      end
      r.hit_total      = hit_count;
      r.miss_total     = miss_count;
      r.eviction_total = eviction_count;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      if (error_count < MAX_PRINTED)
         $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
      error_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Request driver: bursts of words separated by random gaps.
   always @(posedge clock) begin : access_driver
      access_word_type next_access;
      if (!reset && req_valid && req_ready) begin
         predicted_lookups.push_back(predict_lookup(req_cmd, req_address));
         accepted_count++;
      end
      if (!req_valid || req_ready) begin
         if (reset || gap_left != 0 || pending_access.size() == 0) begin
            if (gap_left != 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            next_access = pending_access.pop_front();
            req_valid   <= 1'b1;
            req_cmd     <= next_access.cmd;
            req_address <= next_access.addr;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // Response drain: the stall pattern switches among a few modes.
   always @(posedge clock) begin
      if (drain_left == 0) begin
         drain_mode = drain_mode_type'($urandom_range(0, 3));
         drain_left = $urandom_range(32, 200);
      end else begin
         drain_left--;
      end
      case (drain_mode)
         DRAIN_FREE:         rsp_ready <= 1'b1;
         DRAIN_COIN:         rsp_ready <= 1'($urandom_range(0, 1));
         DRAIN_EVERY_FOURTH: rsp_ready <= (cycle_count[1:0] == 2'd0);
         default:            rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_lookups.size() == 0) begin
            report_mismatch("word with nothing outstanding", 64'd0, 64'd0);
         end else begin
            want = predicted_lookups.pop_front();
            if (rsp_was_hit !== want.was_hit)
               report_mismatch("was_hit", 64'(want.was_hit), 64'(rsp_was_hit));
            if (rsp_was_miss !== want.was_miss)
               report_mismatch("was_miss", 64'(want.was_miss), 64'(rsp_was_miss));
            if (rsp_was_eviction !== want.was_eviction)
               report_mismatch("was_eviction", 64'(want.was_eviction),
                               64'(rsp_was_eviction));
            if (rsp_hit_total !== want.hit_total)
               report_mismatch("hit_total", 64'(want.hit_total), 64'(rsp_hit_total));
            if (rsp_miss_total !== want.miss_total)
               report_mismatch("miss_total", 64'(want.miss_total), 64'(rsp_miss_total));
            if (rsp_eviction_total !== want.eviction_total)
               report_mismatch("eviction_total", 64'(want.eviction_total),
                               64'(rsp_eviction_total));
         end
      end
   end

   task automatic push_access(input cmd_type cmd, input logic [63:0] addr);
      access_word_type a;
      a.cmd = cmd;
      a.addr = addr;
      pending_access.push_back(a);
      issued_count++;
   endtask

   task automatic wait_idle();
      while (accepted_count != issued_count || predicted_lookups.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (csr_index_type'(idx))
         CSR_SET_BITS:    cfg_set_bits = data[3:0];
         CSR_WAYS:        cfg_ways = data[3:0];
         CSR_OFFSET_BITS: cfg_offset_bits = data;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [5:0] sb, input logic [5:0] wy, input logic [5:0] of);
      write_csr(CSR_SET_BITS, sb);
      write_csr(CSR_WAYS, wy);
      write_csr(CSR_OFFSET_BITS, of);
      if ($urandom_range(0, 3) == 0) write_csr(CSR_UNUSED, 6'($urandom));
   endtask

   // Address built from a small set range and a small tag pool, so that
   // lines are reused and sets fill up; some words are plain noise.
   function automatic logic [63:0] random_access_address();
      int unsigned sbits, shift, set_span;
      logic [63:0] a;
      if ($urandom_range(0, 9) == 0) return rand64();
      sbits = eff_set_bits();
      shift = sbits + cfg_offset_bits;
      set_span = (1 << sbits) - 1;
      if (set_span > 3 && $urandom_range(0, 3) != 0) set_span = 3;
      a = rand64() & ((64'd1 << cfg_offset_bits) - 64'd1);
      a |= 64'($urandom_range(0, set_span)) << cfg_offset_bits;
      if (shift < 64) a |= tag_pool[$urandom_range(0, tag_pool.size() - 1)] << shift;
      return a;
   endfunction

   initial begin
      int          phase;
      int unsigned sb, wy, of;
      cmd_type     cmd;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: one set, one way, tag is the whole address.
      push_access(CMD_FETCH, 64'd0);
      push_access(CMD_FETCH, '1);
      push_access(CMD_LOAD, 64'd0);
      push_access(CMD_LOAD, 64'd0);
      push_access(CMD_STORE, 64'd0);
      push_access(CMD_MODIFY, 64'd0);
      push_access(CMD_LOAD, '1);
      push_access(CMD_MODIFY, 64'd0);
      push_access(CMD_STORE, 64'h8000_0000_0000_0000);
      push_access(CMD_LOAD, 64'h5555_5555_5555_5555);
      wait_idle();

      // Set and offset bits cover all 64 address bits, so every tag is zero.
      set_config(6'd8, 6'd8, 6'd56);
      push_access(CMD_LOAD, 64'd0);
      push_access(CMD_LOAD, 64'hFF00_0000_0000_0000);
      push_access(CMD_LOAD, 64'hFF12_3456_789A_BCDE);
      push_access(CMD_MODIFY, '1);
      push_access(CMD_FETCH, 64'hAAAA_AAAA_AAAA_AAAA);
      wait_idle();

      // Two ways in set 1: least recently used line is replaced.
      set_config(6'h32, 6'h02, 6'd4);
      write_csr(CSR_UNUSED, 6'h3F);
      push_access(CMD_LOAD, 64'h57);
      push_access(CMD_STORE, 64'h9A);
      push_access(CMD_LOAD, 64'h57);
      push_access(CMD_MODIFY, 64'hD0);
      push_access(CMD_LOAD, 64'h9A);
      push_access(CMD_STORE, 64'hFFFF_FFFF_FFFF_FF5F);
      wait_idle();

      for (phase = 0; phase < 12; phase++) begin
         case (phase)
            0: set_config(6'h0F, 6'h00, 6'd63);
            1: set_config(6'h38, 6'h0F, 6'd0);
            2: set_config(6'h08, 6'h08, 6'd56);
            default: begin
               sb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
               wy = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
               of = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
               set_config({2'($urandom), 4'(sb)}, {2'($urandom), 4'(wy)}, 6'(of));
            end
         endcase
         tag_pool.delete();
         repeat (eff_ways() + $urandom_range(1, 3))
            tag_pool.push_back($urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 15)));
         repeat (107) begin
            cmd = ($urandom_range(0, 9) == 0) ? CMD_FETCH : cmd_type'($urandom_range(1, 3));
            push_access(cmd, random_access_address());
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== set_assoc_lru_cache_sim_top.f =====
+incdir+rtl
rtl/salru_pkg.sv
rtl/salru_lookup.sv
rtl/set_assoc_lru_cache_sim_top.sv
tb/tb_top.sv
